// ----- rtl/mbrc_pkg.sv -----
// ----------------------------------------------------------------------------
// mbrc_pkg: shared definitions for the Modbus read response checker
// Status codes, CRC-16 constants, register indexes and the CRC control struct.
// ----------------------------------------------------------------------------
package mbrc_pkg;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_SHORT  = 2'd1;
	localparam logic [1:0] ST_CRC    = 2'd2;
	localparam logic [1:0] ST_HEADER = 2'd3;

	// configuration register indexes
	localparam logic CFG_SLAVE_ADDRESS  = 1'b0;
	localparam logic CFG_REGISTER_COUNT = 1'b1;

	// request types
	localparam logic REQ_BYTE    = 1'b0;
	localparam logic REQ_TIMEOUT = 1'b1;

	// CRC-16 (reflected) and protocol constants
	localparam logic [15:0] CRC_INIT          = 16'hFFFF;
	localparam logic [15:0] CRC_POLY          = 16'hA001;
	localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
	localparam logic [3:0]  CRC_STEPS         = 4'd8;

	// control from the sequencer to the CRC unit
	typedef struct packed {
		logic start;    // fold in a new byte and run the bit steps
		logic restart;  // return the accumulator to its initial value
	} crc_ctl_t;

endpackage

// ----- rtl/modbus_read_response_checker.sv -----
// ----------------------------------------------------------------------------
// modbus_read_response_checker: Modbus RTU read-holding-registers reply check
// Collects reply bytes, checks CRC-16, slave address and function code, and
// emits the received register values or one error result.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries req_type and rx_byte. A byte
//   transaction (req_type 0) passes through the accept, the steps of the
//   bit-serial CRC unit, the end of those steps and one frame-end check;
//   in_stall is high after the accept. A timeout transaction (req_type 1)
//   ends the frame at once with a short-frame result.
//   After the final byte of a frame (5 + 2*count bytes) the output channel
//   (out_valid/out_stall) delivers either one error result or one result per
//   register, one per cycle while out_stall is low; a stalled result holds
//   its value and no new byte is taken until the last result is gone.
//   Configuration (cfg_we, cfg_index, cfg_data) is to be written while idle
//   (the block does not enforce this): index 0 slave address, index 1 register count.
//   Reset clears the frame: byte count zero, CRC all ones, header good,
//   address 1 and count 4; register contents are undefined until received.
// ----------------------------------------------------------------------------
module modbus_read_response_checker #(
	parameter int MAX_REGS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [7:0]  rx_byte,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [2:0]  reg_index,
	output logic [15:0] reg_value,
	output logic        last,
	// configuration port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int IDX_W = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
	localparam int CNT_W = $clog2(MAX_REGS + 1);
	localparam logic [5:0] MAX_REGS_W = 6'(MAX_REGS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CRC,
		S_CHECK,
		S_EMIT
	} state_t;

	state_t      state_q;
	logic [7:0]  slave_address_q;
	logic [3:0]  register_count_q;
	logic [4:0]  byte_count_q;
	logic        header_good_q;
	logic [7:0]  high_hold_q;
	logic [7:0]  byte_q;
	logic [4:0]  pos_q;
	logic [15:0] reg_store_q [MAX_REGS];

	logic [CNT_W-1:0] emit_q;
	logic [CNT_W-1:0] nregs_q;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [2:0]  reg_index_q;
	logic [15:0] reg_value_q;
	logic        last_q;

	mbrc_pkg::crc_ctl_t crc_ctl;
	logic [15:0]        crc_value;
	logic               crc_busy;

	logic        in_acc;
	logic        out_acc;
	logic [5:0]  eff_count;
	logic [6:0]  frame_len;
	logic [4:0]  off;
	logic [4:0]  store_idx;
	logic        store_we;
	logic [CNT_W-1:0] emit_nxt;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid_q && !out_stall;
	assign in_stall = (state_q != S_IDLE);

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign reg_index = reg_index_q;
	assign reg_value = reg_value_q;
	assign last      = last_q;

	// clamp the register count into 1..MAX_REGS and derive the frame length
	always_comb begin
		if (register_count_q == 4'd0) begin
			eff_count = 6'd1;
		end else if ({2'd0, register_count_q} > MAX_REGS_W) begin
			eff_count = MAX_REGS_W;
		end else begin
			eff_count = {2'd0, register_count_q};
		end
		frame_len = 7'd5 + {eff_count, 1'b0};
	end

	// place of the accepted byte within the register data
	assign off       = pos_q - 5'd3;
	assign store_idx = {1'b0, off[4:1]};
	assign store_we  = (state_q == S_CHECK) && (pos_q >= 5'd3) && off[0]
		&& ({1'b0, store_idx} < MAX_REGS_W);
	assign emit_nxt  = emit_q + CNT_W'(1);

	// drive the CRC unit
	always_comb begin
		crc_ctl.start   = in_acc && (req_type == mbrc_pkg::REQ_BYTE);
		crc_ctl.restart = (in_acc && (req_type == mbrc_pkg::REQ_TIMEOUT))
			|| ((state_q == S_CHECK) && ({2'd0, byte_count_q} >= frame_len));
	end

	mbrc_crc_unit u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.data   (rx_byte),
		.crc    (crc_value),
		.busy   (crc_busy)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q  <= 8'd1;
			register_count_q <= 4'd4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mbrc_pkg::CFG_SLAVE_ADDRESS:  slave_address_q  <= cfg_data;
				mbrc_pkg::CFG_REGISTER_COUNT: register_count_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// register store: write the assembled value once its low byte arrives
	always_ff @(posedge clk) begin
		if (store_we) begin
			reg_store_q[store_idx[IDX_W-1:0]] <= {high_hold_q, byte_q};
		end
	end

	// hold the high byte of the register being assembled
	always_ff @(posedge clk) begin
		if ((state_q == S_CHECK) && (pos_q >= 5'd3) && !off[0]) begin
			high_hold_q <= byte_q;
		end
	end

	// sequencer: byte intake, frame-end judgement and result delivery
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			byte_count_q  <= 5'd0;
			header_good_q <= 1'b1;
			out_valid_q   <= 1'b0;
			emit_q        <= '0;
			nregs_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (req_type == mbrc_pkg::REQ_TIMEOUT) begin
							status_q      <= mbrc_pkg::ST_SHORT;
							reg_index_q   <= 3'd0;
							reg_value_q   <= 16'd0;
							last_q        <= 1'b1;
							out_valid_q   <= 1'b1;
							byte_count_q  <= 5'd0;
							header_good_q <= 1'b1;
							state_q       <= S_EMIT;
						end else begin
							byte_q       <= rx_byte;
							pos_q        <= byte_count_q;
							byte_count_q <= byte_count_q + 5'd1;
							if ((byte_count_q == 5'd0) && (rx_byte != slave_address_q)) begin
								header_good_q <= 1'b0;
							end
							if ((byte_count_q == 5'd1)
								&& (rx_byte != mbrc_pkg::FUNC_READ_HOLDING)) begin
								header_good_q <= 1'b0;
							end
							state_q <= S_CRC;
						end
					end
				end
				S_CRC: begin
					if (!crc_busy) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if ({2'd0, byte_count_q} < frame_len) begin
						state_q <= S_IDLE;
					end else begin
						byte_count_q  <= 5'd0;
						header_good_q <= 1'b1;
						out_valid_q   <= 1'b1;
						state_q       <= S_EMIT;
						reg_index_q   <= 3'd0;
						priority if (crc_value != 16'd0) begin
							status_q    <= mbrc_pkg::ST_CRC;
							reg_value_q <= 16'd0;
							last_q      <= 1'b1;
						end else if (!header_good_q) begin
							status_q    <= mbrc_pkg::ST_HEADER;
							reg_value_q <= 16'd0;
							last_q      <= 1'b1;
						end else begin
							status_q    <= mbrc_pkg::ST_OK;
							reg_value_q <= reg_store_q[0];
							last_q      <= (eff_count == 6'd1);
							nregs_q     <= CNT_W'(eff_count);
							emit_q      <= '0;
						end
					end
				end
				S_EMIT: begin
					if (out_acc) begin
						if (last_q) begin
							out_valid_q <= 1'b0;
							state_q     <= S_IDLE;
						end else begin
							emit_q      <= emit_nxt;
							reg_index_q <= 3'(emit_nxt);
							reg_value_q <= reg_store_q[emit_nxt[IDX_W-1:0]];
							last_q      <= ((emit_nxt + CNT_W'(1)) == nregs_q);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// results are only presented while delivering
	a_valid_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (state_q == S_EMIT))
		else $error("result presented outside delivery");

	// an error result is always the only and final one, with empty data
	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q != mbrc_pkg::ST_OK))
		|-> (last_q && (reg_value_q == 16'd0) && (reg_index_q == 3'd0)))
		else $error("error result not final or not empty");

	// the CRC unit only steps while the sequencer waits for it
	a_crc_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		crc_busy |-> (state_q == S_CRC))
		else $error("CRC unit busy outside CRC wait");

	// a byte transaction always starts the CRC unit
	a_byte_starts_crc: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (req_type == mbrc_pkg::REQ_BYTE)) |=> crc_busy)
		else $error("accepted byte did not start the CRC unit");

endmodule

// ----- rtl/mbrc_crc_unit.sv -----
// ----------------------------------------------------------------------------
// mbrc_crc_unit: bit-serial CRC-16 accumulator
// Folds one byte into the running CRC, then applies eight shift/xor steps, one
// per cycle. busy is high while steps remain.
// ----------------------------------------------------------------------------
module mbrc_crc_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  mbrc_pkg::crc_ctl_t ctl,
	input  logic [7:0]        data,
	output logic [15:0]       crc,
	output logic              busy
);

	logic [15:0] crc_q;
	logic [3:0]  steps_q;

	assign busy = (steps_q != 4'd0);
	assign crc  = crc_q;

	// hold the accumulator; advance one polynomial step per cycle while busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= mbrc_pkg::CRC_INIT;
			steps_q <= 4'd0;
		end else if (ctl.restart) begin
			crc_q   <= mbrc_pkg::CRC_INIT;
			steps_q <= 4'd0;
		end else if (ctl.start) begin
			crc_q   <= crc_q ^ {8'd0, data};
			steps_q <= mbrc_pkg::CRC_STEPS;
		end else if (busy) begin
			if (crc_q[0]) begin
				crc_q <= (crc_q >> 1) ^ mbrc_pkg::CRC_POLY;
			end else begin
				crc_q <= crc_q >> 1;
			end
			steps_q <= steps_q - 4'd1;
		end
	end

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for modbus_read_response_checker
// Walks a short table of directed reply bytes and timeouts, then streams random
// frames (mostly well formed, some damaged) under three idling regimes. A
// frame decoder kept in step with every accepted transaction predicts each
// reply, and the monitor compares every accepted result against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int          NUM_REGS      = 8;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned CYCLE_LIMIT   = 400000;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  idx;
		logic [15:0] value;
		logic        last;
	} reply_t;

	typedef enum logic [2:0] {
		ROW_BYTE, ROW_CRC, ROW_BAD_CRC, ROW_TIMEOUT, ROW_ADDR, ROW_COUNT
	} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		logic [7:0] data;
		logic       typed;
		reply_t     want;
	} stim_row_t;

	localparam reply_t NO_REPLY     = '0;
	localparam reply_t SHORT_REPLY  =
		reply_t'({mbrc_pkg::ST_SHORT, 3'd0, 16'd0, 1'b1});
	localparam reply_t CRC_REPLY    =
		reply_t'({mbrc_pkg::ST_CRC, 3'd0, 16'd0, 1'b1});
	localparam reply_t HEADER_REPLY =
		reply_t'({mbrc_pkg::ST_HEADER, 3'd0, 16'd0, 1'b1});

	// directed plan; CRC rows carry the running checksum, typed rows their own reply
	localparam stim_row_t DIRECTED_PLAN [0:27] = '{
		'{ROW_TIMEOUT, 8'h00, 1'b1, SHORT_REPLY},   // timeout straight after reset
		'{ROW_BYTE,    8'h01, 1'b0, NO_REPLY},
		'{ROW_TIMEOUT, 8'hFF, 1'b1, SHORT_REPLY},   // timeout part way into a frame
		'{ROW_COUNT,   8'h0F, 1'b0, NO_REPLY},      // above the maximum, clipped to 8
		'{ROW_ADDR,    8'hFF, 1'b0, NO_REPLY},
		'{ROW_BYTE,    8'hFF, 1'b0, NO_REPLY},
		'{ROW_BYTE,    8'h03, 1'b0, NO_REPLY},
		'{ROW_BYTE,    8'h10, 1'b0, NO_REPLY},
		'{ROW_BYTE,    8'hAA, 1'b0, NO_REPLY},
		'{ROW_BYTE,    8'hBB, 1'b0, NO_REPLY},
		'{ROW_COUNT,   8'h00, 1'b0, NO_REPLY},      // zero taken as one, shortens the frame
		'{ROW_CRC,     8'h00, 1'b0, NO_REPLY},
		'{ROW_CRC,     8'h00, 1'b0, NO_REPLY},
		'{ROW_BYTE,    8'h00, 1'b0, NO_REPLY},      // wrong address and wrong function
		'{ROW_BYTE,    8'h04, 1'b0, NO_REPLY},
		'{ROW_BYTE,    8'h02, 1'b0, NO_REPLY},
		'{ROW_BYTE,    8'h12, 1'b0, NO_REPLY},
		'{ROW_BYTE,    8'h34, 1'b0, NO_REPLY},
		'{ROW_CRC,     8'h00, 1'b0, NO_REPLY},
		'{ROW_BAD_CRC, 8'h00, 1'b1, CRC_REPLY},     // CRC error wins over the header
		'{ROW_ADDR,    8'h00, 1'b0, NO_REPLY},
		'{ROW_BYTE,    8'h00, 1'b0, NO_REPLY},
		'{ROW_BYTE,    8'h83, 1'b0, NO_REPLY},      // exception-style function code
		'{ROW_BYTE,    8'h02, 1'b0, NO_REPLY},
		'{ROW_BYTE,    8'hFF, 1'b0, NO_REPLY},
		'{ROW_BYTE,    8'hFF, 1'b0, NO_REPLY},
		'{ROW_CRC,     8'h00, 1'b0, NO_REPLY},
		'{ROW_CRC,     8'h00, 1'b1, HEADER_REPLY}
	};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic        req_type  = 1'b0;
	logic [7:0]  rx_byte   = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [2:0]  reg_index;
	logic [15:0] reg_value;
	logic        last;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = 1'b0;
	logic [7:0]  cfg_data  = 8'h00;

	// frame decoder state and its copy of the configuration
	logic [7:0]  want_addr;
	logic [3:0]  want_count;
	logic [4:0]  rx_count;
	logic [15:0] frame_crc;
	logic        hdr_ok;
	logic [7:0]  hi_byte;
	logic [15:0] reg_words [NUM_REGS];

	reply_t      expected_q [$];
	reply_t      fresh [$];

	int unsigned send_gap_pct = 11;
	int unsigned stall_pct    = 72;
	int unsigned items_sent   = 0;
	int unsigned replies_seen = 0;
	int unsigned mismatches   = 0;
	int unsigned cycle_count  = 0;

	modbus_read_response_checker #(.MAX_REGS(NUM_REGS)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.reg_index (reg_index),
		.reg_value (reg_value),
		.last      (last),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// abort a run that hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- decoder

	function automatic logic [15:0] crc_feed(logic [15:0] c, logic [7:0] b);
		c = c ^ {8'h00, b};
		repeat (8) c = c[0] ? ((c >> 1) ^ mbrc_pkg::CRC_POLY) : (c >> 1);
		return c;
	endfunction

	function automatic int unsigned regs_expected();
		int unsigned n;
		n = want_count;
		if (n == 0) n = 1;
		if (n > NUM_REGS) n = NUM_REGS;
		return n;
	endfunction

	function automatic void restart_frame();
		rx_count  = 5'd0;
		frame_crc = mbrc_pkg::CRC_INIT;
		hdr_ok    = 1'b1;
	endfunction

	function automatic void reset_decoder();
		want_addr  = 8'd1;
		want_count = 4'd4;
		hi_byte    = 8'h00;
		foreach (reg_words[k]) reg_words[k] = 16'h0000;
		restart_frame();
	endfunction

	// advance the decoder by one transaction and leave its replies in fresh
	function automatic void decode_step(logic rq, logic [7:0] b);
		int unsigned n, i, slot;
		fresh.delete();
		if (rq == mbrc_pkg::REQ_TIMEOUT) begin
			fresh.push_back(SHORT_REPLY);
			restart_frame();
			return;
		end
		frame_crc = crc_feed(frame_crc, b);
		if (rx_count == 5'd0 && b != want_addr) hdr_ok = 1'b0;
		if (rx_count == 5'd1 && b != mbrc_pkg::FUNC_READ_HOLDING) hdr_ok = 1'b0;
		// odd positions from 3 on hold a high byte, even ones complete a word
		if (rx_count >= 5'd3) begin
			if (rx_count[0]) begin
				hi_byte = b;
			end else begin
				slot = (rx_count - 4) / 2;
				if (slot < NUM_REGS) reg_words[slot] = {hi_byte, b};
			end
		end
		rx_count = rx_count + 5'd1;
		n = regs_expected();
		if (rx_count < 5 + 2 * n) return;
		// frame complete: CRC first, then header, then the register words
		if (frame_crc != 16'h0000) begin
			fresh.push_back(CRC_REPLY);
		end else if (!hdr_ok) begin
			fresh.push_back(HEADER_REPLY);
		end else begin
			for (i = 0; i < n; i++)
				fresh.push_back(reply_t'({mbrc_pkg::ST_OK, 3'(i), reg_words[i],
					(i + 1 == n)}));
		end
		restart_frame();
	endfunction

	// ---------------------------------------------------------------- monitor

	function automatic void report_reply(reply_t want, reply_t got, bit orphan);
		mismatches++;
		if (mismatches > 10) return;
		if (orphan)
			$display("unexpected reply: st=%0d idx=%0d val=%h last=%0b",
				got.status, got.idx, got.value, got.last);
		else
			$display({"reply mismatch: expected st=%0d idx=%0d val=%h last=%0b, ",
				"got st=%0d idx=%0d val=%h last=%0b"},
				want.status, want.idx, want.value, want.last,
				got.status, got.idx, got.value, got.last);
	endfunction

	// stall the output at random and check each transaction that goes through
	always @(posedge clk) begin
		reply_t got, want;
		out_stall <= arst_n && ($urandom_range(99) < stall_pct);
		if (arst_n && out_valid && !out_stall) begin
			got = reply_t'({status, reg_index, reg_value, last});
			replies_seen++;
			if (expected_q.size() == 0) begin
				report_reply(NO_REPLY, got, 1'b1);
			end else begin
				want = expected_q.pop_front();
				if (got.status !== want.status || got.idx !== want.idx ||
				    got.value !== want.value || got.last !== want.last)
					report_reply(want, got, 1'b0);
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	// drive one transaction, wait for acceptance, then record what it should give
	task automatic send_item(input logic rq, input logic [7:0] b, input logic typed,
		input reply_t want);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall);
		items_sent++;
		decode_step(rq, b);
		if (typed) expected_q.push_back(want);
		else foreach (fresh[k]) expected_q.push_back(fresh[k]);
	endtask

	// hold off until every predicted reply is out, optionally letting the block settle
	task automatic wait_idle(input bit settle);
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_q.size() != 0);
		if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic idx, input logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		if (idx == mbrc_pkg::CFG_SLAVE_ADDRESS) want_addr = value;
		else want_count = value[3:0];
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] data_byte();
		if ($urandom_range(7) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
		return 8'($urandom_range(255));
	endfunction

	// one random frame: mostly clean, some damaged, truncated or plain noise
	task automatic random_frame();
		int unsigned pick, n, len, cut, i;
		logic [7:0] b;
		pick = $urandom_range(99);
		if ($urandom_range(24) == 0) wait_idle(1'b0);
		if (rx_count != 5'd0 && $urandom_range(1))
			send_item(mbrc_pkg::REQ_TIMEOUT, 8'($urandom_range(255)), 1'b0, NO_REPLY);
		if (pick < 6) begin
			send_item(mbrc_pkg::REQ_TIMEOUT, 8'($urandom_range(255)), 1'b0, NO_REPLY);
			return;
		end
		if (pick < 12) begin
			repeat ($urandom_range(1, 6))
				send_item(mbrc_pkg::REQ_BYTE, data_byte(), 1'b0, NO_REPLY);
			return;
		end
		n   = regs_expected();
		len = 5 + 2 * n;
		cut = (pick < 20) ? $urandom_range(1, len - 1) : len;
		for (i = 0; i < cut; i++) begin
			if (i == 0)
				b = (pick >= 20 && pick < 27) ?
					want_addr ^ 8'($urandom_range(1, 255)) : want_addr;
			else if (i == 1)
				b = (pick >= 27 && pick < 33) ?
					mbrc_pkg::FUNC_READ_HOLDING ^ 8'($urandom_range(1, 255)) :
					mbrc_pkg::FUNC_READ_HOLDING;
			else if (i == 2)
				b = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'(2 * n);
			else if (i >= len - 2)
				b = (pick >= 33 && pick < 43 && (i - (len - 2)) == pick % 2) ?
					frame_crc[7:0] ^ 8'($urandom_range(1, 255)) : frame_crc[7:0];
			else
				b = data_byte();
			send_item(mbrc_pkg::REQ_BYTE, b, 1'b0, NO_REPLY);
		end
		if (cut < len)
			send_item(mbrc_pkg::REQ_TIMEOUT, 8'($urandom_range(255)), 1'b0, NO_REPLY);
	endtask

	initial begin
		int unsigned ph, base_items, base_replies;
		reset_decoder();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed plan
		foreach (DIRECTED_PLAN[r]) begin
			case (DIRECTED_PLAN[r].kind)
				ROW_ADDR: begin
					wait_idle(1'b1);
					cfg_write(mbrc_pkg::CFG_SLAVE_ADDRESS, DIRECTED_PLAN[r].data);
				end
				ROW_COUNT: begin
					wait_idle(1'b1);
					cfg_write(mbrc_pkg::CFG_REGISTER_COUNT, DIRECTED_PLAN[r].data);
				end
				ROW_TIMEOUT: send_item(mbrc_pkg::REQ_TIMEOUT, DIRECTED_PLAN[r].data,
					DIRECTED_PLAN[r].typed, DIRECTED_PLAN[r].want);
				ROW_CRC: send_item(mbrc_pkg::REQ_BYTE, frame_crc[7:0],
					DIRECTED_PLAN[r].typed, DIRECTED_PLAN[r].want);
				ROW_BAD_CRC: send_item(mbrc_pkg::REQ_BYTE, frame_crc[7:0] ^ 8'h5A,
					DIRECTED_PLAN[r].typed, DIRECTED_PLAN[r].want);
				default: send_item(mbrc_pkg::REQ_BYTE, DIRECTED_PLAN[r].data,
					DIRECTED_PLAN[r].typed, DIRECTED_PLAN[r].want);
			endcase
		end

		// random phases: receiver stalls, then sender gaps, then full rate
		for (ph = 0; ph < 3; ph++) begin
			wait_idle(1'b1);
			case (ph)
				0: begin send_gap_pct = 11; stall_pct = 72; end
				1: begin send_gap_pct = 72; stall_pct = 11; end
				default: begin send_gap_pct = 0; stall_pct = 0; end
			endcase
			cfg_write(mbrc_pkg::CFG_SLAVE_ADDRESS, 8'($urandom_range(255)));
			cfg_write(mbrc_pkg::CFG_REGISTER_COUNT, (ph == 0) ? 8'd8 :
				(ph == 1) ? 8'($urandom_range(1, 7)) : 8'($urandom_range(15)));
			base_items   = items_sent;
			base_replies = replies_seen;
			while (items_sent - base_items < 30 || replies_seen - base_replies < 8)
				random_frame();
			// leave a partial frame behind now and then, so the next setting lands mid-frame
			if ($urandom_range(1))
				repeat ($urandom_range(1, 3))
					send_item(mbrc_pkg::REQ_BYTE, data_byte(), 1'b0, NO_REPLY);
		end

		wait_idle(1'b1);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/mbrc_pkg.sv
rtl/mbrc_crc_unit.sv
rtl/modbus_read_response_checker.sv
tb/sv/tb_top.sv
